// File: hdl/kcmh_pkg.sv
`timescale 1ns / 1ps

package kcmh_pkg;

   // Data widths.
   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = 32;
   localparam int unsigned FRAC_W = 53;

   // Finalizer constants.
   localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;
   localparam int unsigned SHIFT_PRE = 30;
   localparam int unsigned SHIFT_MID = 27;
   localparam int unsigned SHIFT_END = 31;
   localparam int unsigned FRAC_SHIFT = 11;

   // Register map of the configuration port.
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_SEED_VALUE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNTER_ENABLE = 1'd1;

   // Request commands.
   localparam logic CMD_KEY = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Partial product steps of one 64-bit multiply.
   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_HL = 2'd1;
   localparam logic [1:0] STEP_LH = 2'd2;
   localparam logic [1:0] STEP_FIN = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_DONE = 3'b100
   } state_type;

endpackage

// File: hdl/kcmh_if.sv
`timescale 1ns / 1ps

// Request channel: one key or one clear command per request.
interface kcmh_req_if;
   import kcmh_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [WORD_W-1:0] key_value;
   logic              last_key;

   modport source (output valid, output cmd, output key_value, output last_key,
                   input ready);
   modport sink (input valid, input cmd, input key_value, input last_key,
                 output ready);
endinterface

// Response channel: one result per finished call.
interface kcmh_rsp_if;
   import kcmh_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_out;
   logic [FRAC_W-1:0] fraction_bits;
   logic [WORD_W-1:0] calls_counted;

   modport source (output valid, output hash_out, output fraction_bits,
                   output calls_counted, input ready);
   modport sink (input valid, input hash_out, input fraction_bits,
                 input calls_counted, output ready);
endinterface

// File: hdl/keyed_counter_mix_hash.sv
`timescale 1ns / 1ps
// A clear is handled in the idle state; a key runs two multiplies on one 32x32 multiplier,
// each through steps LL, HL, LH and FIN. A non-last key then returns to idle; a last key
// goes on to the result state, and when the counter is folded in, two more multiplies come first.
// A request is taken only in the idle state, so a key must finish before another request is
// taken; a response held by the sink stalls the result state.
// Reset (synchronous, active high) clears seed, counter enable, call counter and call state.
module keyed_counter_mix_hash
   import kcmh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wr_data,
   kcmh_req_if.sink             req_ch,
   kcmh_rsp_if.source           rsp_ch
);

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] seed_ff;
   logic              ctr_en_ff;
   logic [WORD_W-1:0] counter_ff, counter_in;
   logic              in_call_ff, in_call_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic [WORD_W-1:0] opnd_ff, opnd_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              half_ff, half_in;
   logic              fold_ff, fold_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic [WORD_W-1:0] rsp_count_ff, rsp_count_in;

   logic              req_fire;
   logic              rsp_free;
   logic [WORD_W-1:0] start_v;
   logic [WORD_W-1:0] mul_const;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [WORD_W-1:0] mid_v, end_v, ctr_v;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         ctr_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SEED_VALUE:     seed_ff <= csr_wr_data;
            REG_COUNTER_ENABLE: ctr_en_ff <= csr_wr_data[0];
            default:            ;
         endcase
      end
   end

   // Handshake signals.
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // Shared multiplier: one 32x32 partial product per step.
   assign mul_const = half_ff ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a = (step_ff == STEP_HL) ? opnd_ff[WORD_W-1:HALF_W] : opnd_ff[HALF_W-1:0];
   assign mul_b = (step_ff == STEP_LH) ? mul_const[WORD_W-1:HALF_W] : mul_const[HALF_W-1:0];
   assign prod_in = WORD_W'(mul_a) * WORD_W'(mul_b);

   // Accumulate the partial products into the low 64 bits of the full product.
   always_comb begin
      acc_in = acc_ff;
      if (step_ff == STEP_HL) begin
         acc_in = prod_ff;
      end else if (step_ff == STEP_LH || step_ff == STEP_FIN) begin
         acc_in = {acc_ff[WORD_W-1:HALF_W] + prod_ff[HALF_W-1:0], acc_ff[HALF_W-1:0]};
      end
   end

   // Shift and xor steps around the two multiplies.
   assign start_v = (in_call_ff ? hash_ff : seed_ff) ^ req_ch.key_value;
   assign mid_v = acc_in ^ (acc_in >> SHIFT_MID);
   assign end_v = acc_in ^ (acc_in >> SHIFT_END);
   assign ctr_v = end_v ^ counter_ff;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      counter_in = counter_ff;
      in_call_in = in_call_ff;
      hash_in = hash_ff;
      opnd_in = opnd_ff;
      step_in = step_ff;
      half_in = half_ff;
      fold_in = fold_ff;
      last_in = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_hash_in = rsp_hash_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.cmd == CMD_CLEAR) begin
                  counter_in = '0;
               end else begin
                  opnd_in = start_v ^ (start_v >> SHIFT_PRE);
                  step_in = STEP_LL;
                  half_in = 1'b0;
                  fold_in = req_ch.last_key && ctr_en_ff;
                  last_in = req_ch.last_key;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == STEP_FIN) begin
               step_in = STEP_LL;
               if (!half_ff) begin
                  opnd_in = mid_v;
                  half_in = 1'b1;
               end else if (fold_ff) begin
                  // Fold the counter value before its increment.
                  opnd_in = ctr_v ^ (ctr_v >> SHIFT_PRE);
                  half_in = 1'b0;
                  fold_in = 1'b0;
                  counter_in = counter_ff + WORD_W'(1);
               end else begin
                  hash_in = end_v;
                  in_call_in = !last_ff;
                  state_in = last_ff ? S_DONE : S_IDLE;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in = hash_ff;
               rsp_count_in = counter_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         counter_ff <= '0;
         in_call_ff <= 1'b0;
         step_ff <= STEP_LL;
         half_ff <= 1'b0;
         fold_ff <= 1'b0;
         last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         counter_ff <= counter_in;
         in_call_ff <= in_call_in;
         step_ff <= step_in;
         half_ff <= half_in;
         fold_ff <= fold_in;
         last_ff <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      opnd_ff <= opnd_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Response outputs.
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.hash_out = rsp_hash_ff;
   assign rsp_ch.fraction_bits = FRAC_W'(rsp_hash_ff >> FRAC_SHIFT);
   assign rsp_ch.calls_counted = rsp_count_ff;

   // A clear request zeroes the call counter on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.cmd == CMD_CLEAR |=> counter_ff == '0)
      else $error("call counter not cleared");

   // A new response appears only out of the result state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside result state");

   // The result state never overwrites a response that is still pending.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_ch.ready |=> state_ff == S_DONE)
      else $error("pending response overwritten");

endmodule
